// ----- rtl/wwlc_pkg.sv -----
// Package: widths, character codes, register map and sequencer states for the line counter.
`timescale 1ns / 1ps
package wwlc_pkg;

  localparam int BYTE_W   = 8;
  localparam int MAXLEN_W = 10;
  localparam int TAB_W    = 7;
  localparam int COL_W    = 11;
  localparam int SINCE_W  = 10;
  localparam int LINES_W  = 32;
  localparam int BACK_W   = 10;

  // Working column before masking: column + 1 can reach 2^COL_W.
  localparam int PCOL_W   = COL_W + 1;
  localparam int DIV_STEPS = PCOL_W;
  localparam int CNT_W    = $clog2(DIV_STEPS);

  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam logic [BYTE_W-1:0] LINE_FEED  = 8'h0A;
  localparam logic [BYTE_W-1:0] TAB_CHAR   = 8'h09;
  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

  localparam logic [SINCE_W-1:0]  SINCE_MAX = {SINCE_W{1'b1}};
  localparam logic [LINES_W-1:0]  LINES_MAX = {LINES_W{1'b1}};

  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 10'd80;
  localparam logic [TAB_W-1:0]    TAB_RESET    = 7'd8;

  // Register index, taken from paddr[2].
  localparam logic REG_WRAP_LEN = 1'b0;
  localparam logic REG_TAB_SIZE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_FIN
  } wwlc_state_t;

endpackage

// ----- rtl/wwlc_if.sv -----
// Valid/ready channel interfaces for text bytes in and line results out.
`timescale 1ns / 1ps
interface wwlc_in_if import wwlc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              is_last;

  modport source (output valid, output text_byte, output is_last, input ready);
  modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

interface wwlc_out_if import wwlc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               break_made;
  logic [BACK_W-1:0]  break_back;
  logic [LINES_W-1:0] lines_so_far;
  logic               final_flag;

  modport source (output valid, output break_made, output break_back,
                  output lines_so_far, output final_flag, input ready);
  modport sink   (input valid, input break_made, input break_back,
                  input lines_so_far, input final_flag, output ready);
endinterface

// ----- rtl/word_wrap_line_counter_unit.sv -----
// Top level: greedy word-wrap line counter with iterative tab-stop remainder.
`timescale 1ns / 1ps
// word_wrap_line_counter_unit
//
// in_ch  : one request per text byte (text_byte, is_last). in_ch.ready is high
//          only while the sequencer is idle; one byte is in work at a time.
// out_ch : one result request per byte (break_made, break_back, lines_so_far,
//          final_flag), held in an output register until out_ch.ready.
// cfg_*  : APB-style write/read of the line length (0x0) and tab_size (0x4),
//          pready tied high. Write only while idle.
//
// Sequence: accept in idle -> evaluate state -> commit state. A tab that is
// not the last byte also passes through the restoring-remainder unit
// between evaluate and commit (one quotient bit per cycle over the 12-bit
// working column).
// The next byte is taken as soon as the result is parked in the output
// register; if the receiver stalls with a result still held, the next result
// waits in the commit state and in_ch.ready stays low until the register frees.
//
// Reset (rst_n low, synchronous): column, whitespace tracking and the line
// count clear, the line length returns to 80 and tab_size to 8, no result is
// pending. After a byte with is_last the text state clears again.
module word_wrap_line_counter_unit import wwlc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  wwlc_in_if.sink           in_ch,
  wwlc_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // ---------------------------------------------------------------- config
  logic [MAXLEN_W-1:0] max_len_r;
  logic [TAB_W-1:0]    tab_size_r;
  logic                cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= MAXLEN_RESET;
      tab_size_r <= TAB_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_WRAP_LEN: max_len_r  <= cfg_pwdata[MAXLEN_W-1:0];
        REG_TAB_SIZE: tab_size_r <= cfg_pwdata[TAB_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_WRAP_LEN: cfg_prdata = {{(APB_DW-MAXLEN_W){1'b0}}, max_len_r};
      REG_TAB_SIZE: cfg_prdata = {{(APB_DW-TAB_W){1'b0}}, tab_size_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // Tab size zero behaves as one.
  logic [TAB_W-1:0] ts_eff;
  assign ts_eff = (tab_size_r == '0) ? TAB_W'(1) : tab_size_r;

  // ---------------------------------------------------------------- state
  wwlc_state_t state_r, state_nxt;

  logic [COL_W-1:0]   column_r;
  logic [SINCE_W-1:0] since_r;
  logic               space_seen_r;
  logic [LINES_W-1:0] line_total_r;

  // captured request
  logic [BYTE_W-1:0]  byte_r;
  logic               last_r;

  // pending result
  logic               res_made_r;
  logic [BACK_W-1:0]  res_back_r;
  logic [LINES_W-1:0] res_lines_r;

  // remainder unit
  logic [PCOL_W-1:0]  pcol_r;
  logic [PCOL_W-1:0]  dvd_r;
  logic [TAB_W-1:0]   rem_r;
  logic [CNT_W-1:0]   cnt_r;

  // output register
  logic               out_valid_r;
  logic               out_made_r;
  logic [BACK_W-1:0]  out_back_r;
  logic [LINES_W-1:0] out_lines_r;
  logic               out_final_r;

  // ---------------------------------------------------------------- evaluate
  // One byte's column/whitespace/line update, all but the tab stop.
  logic [PCOL_W-1:0]  col_inc;
  logic [COL_W-1:0]   k_cnt;
  logic               fits;
  logic [PCOL_W-1:0]  ev_pcol;
  logic [COL_W-1:0]   ev_col;
  logic [SINCE_W-1:0] ev_since;
  logic               ev_space;
  logic               ev_made;
  logic [BACK_W-1:0]  ev_back;
  logic               ev_tab;
  logic               ev_lf;      // byte ends as newline
  logic               ev_ss_in;
  logic [1:0]         ev_adds;
  logic [LINES_W:0]   lines_sum;
  logic [LINES_W-1:0] ev_lines;
  logic               do_plain;

  always_comb begin
    col_inc  = {1'b0, column_r} + PCOL_W'(1);
    k_cnt    = {1'b0, since_r} + COL_W'(1);
    fits     = col_inc < {{(PCOL_W-MAXLEN_W){1'b0}}, max_len_r};
    ev_pcol  = col_inc;
    ev_ss_in = space_seen_r;
    ev_made  = 1'b0;
    ev_back  = '0;
    ev_col   = '0;
    ev_since = since_r;
    ev_space = space_seen_r;
    ev_tab   = 1'b0;
    ev_lf    = 1'b0;
    do_plain = 1'b1;
    ev_adds  = 2'd0;

    if (!fits) begin
      ev_made  = 1'b1;
      ev_adds  = 2'd1;
      ev_since = '0;
      ev_space = 1'b0;
      ev_ss_in = 1'b0;
      if (space_seen_r) begin
        // earlier whitespace turns into the newline, recount after it
        ev_back = k_cnt[COL_W-1] ? SINCE_MAX : k_cnt[BACK_W-1:0];
        ev_pcol = {1'b0, k_cnt};
      end else begin
        // no whitespace on the line: this byte is replaced
        do_plain = 1'b0;
        ev_lf    = 1'b1;
      end
    end

    if (do_plain) begin
      ev_col = ev_pcol[COL_W-1:0];
      case (byte_r)
        LINE_FEED: begin
          ev_adds  = ev_adds + 2'd1;
          ev_lf    = 1'b1;
          ev_col   = '0;
          ev_space = 1'b0;
          ev_since = '0;
        end
        TAB_CHAR: begin
          ev_tab   = 1'b1;
          ev_space = 1'b1;
          ev_since = '0;
        end
        SPACE_CHAR: begin
          ev_space = 1'b1;
          ev_since = '0;
        end
        default: begin
          if (ev_ss_in && (ev_since != SINCE_MAX)) ev_since = ev_since + SINCE_W'(1);
        end
      endcase
    end

    if (last_r && !ev_lf) ev_adds = ev_adds + 2'd1;

    lines_sum = {1'b0, line_total_r} + {{(LINES_W-1){1'b0}}, ev_adds};
    ev_lines  = lines_sum[LINES_W] ? LINES_MAX : lines_sum[LINES_W-1:0];
  end

  // ---------------------------------------------------------------- remainder step
  // Restoring remainder, one dividend bit per cycle.
  logic [TAB_W:0]     div_trial;
  logic [TAB_W-1:0]   div_rem;
  logic [PCOL_W:0]    tab_sum;
  logic [COL_W-1:0]   tab_col;
  logic               div_done;

  always_comb begin
    div_trial = {rem_r, dvd_r[PCOL_W-1]};
    if (div_trial >= {1'b0, ts_eff}) div_rem = TAB_W'(div_trial - {1'b0, ts_eff});
    else                             div_rem = div_trial[TAB_W-1:0];
    tab_sum  = {1'b0, pcol_r} + {{(PCOL_W-TAB_W+1){1'b0}}, ts_eff}
             - {{(PCOL_W-TAB_W+1){1'b0}}, div_rem};
    tab_col  = tab_sum[COL_W-1:0];
    div_done = (cnt_r == CNT_W'(DIV_STEPS-1));
  end

  // ---------------------------------------------------------------- sequencer
  logic out_free;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = (ev_tab && !last_r) ? ST_DIV : ST_FIN;
      ST_DIV:  if (div_done) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic accept_in, eval_go, div_go, fin_go;

  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    accept_in   = (state_r == ST_IDLE) && in_ch.valid;
    eval_go     = (state_r == ST_EVAL);
    div_go      = (state_r == ST_DIV);
    fin_go      = (state_r == ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // text state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r     <= '0;
      since_r      <= '0;
      space_seen_r <= 1'b0;
      line_total_r <= '0;
    end else if (eval_go) begin
      if (last_r) begin
        column_r     <= '0;
        since_r      <= '0;
        space_seen_r <= 1'b0;
        line_total_r <= '0;
      end else begin
        column_r     <= ev_col;
        since_r      <= ev_since;
        space_seen_r <= ev_space;
        line_total_r <= ev_lines;
      end
    end else if (div_go && div_done) begin
      column_r <= tab_col;
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (accept_in) begin
      byte_r <= in_ch.text_byte;
      last_r <= in_ch.is_last;
    end
    if (eval_go) begin
      res_made_r  <= ev_made;
      res_back_r  <= ev_back;
      res_lines_r <= ev_lines;
      pcol_r      <= ev_pcol;
      dvd_r       <= ev_pcol;
      rem_r       <= '0;
    end else if (div_go) begin
      dvd_r <= {dvd_r[PCOL_W-2:0], 1'b0};
      rem_r <= div_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)       cnt_r <= '0;
    else if (eval_go) cnt_r <= '0;
    else if (div_go)  cnt_r <= cnt_r + CNT_W'(1);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n)                   out_valid_r <= 1'b0;
    else if (fin_go)              out_valid_r <= 1'b1;
    else if (out_ch.ready)        out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_made_r  <= res_made_r;
      out_back_r  <= res_back_r;
      out_lines_r <= res_lines_r;
      out_final_r <= last_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.break_made   = out_made_r;
  assign out_ch.break_back   = out_back_r;
  assign out_ch.lines_so_far = out_lines_r;
  assign out_ch.final_flag   = out_final_r;

endmodule

// ----- rtl/wwlc_checker.sv -----
// Port-level assertions for the line counter, bound to the top level.
`timescale 1ns / 1ps
module wwlc_checker import wwlc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               break_made,
  input logic [BACK_W-1:0]  break_back,
  input logic [LINES_W-1:0] lines_so_far
);

  // a held result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one byte in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_back_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !break_made |-> break_back == '0)
    else $error("break_back set without a break");

  // a break always counts a line
  a_break_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && break_made |-> lines_so_far != '0)
    else $error("break reported with zero lines");

endmodule

bind word_wrap_line_counter_unit wwlc_checker u_wwlc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .break_made   (out_ch.break_made),
  .break_back   (out_ch.break_back),
  .lines_so_far (out_ch.lines_so_far)
);

// ----- dv/wwlc_line_checker.sv -----
// Checker: watches the text and result channels and the register port, predicts and compares.
`timescale 1ns / 1ps
module wwlc_line_checker import wwlc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  wwlc_in_if                in_mon,
  wwlc_out_if               out_mon,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output int                errors,
  output int                pending,
  output int                results_seen,
  output int                breaks_seen
);

  typedef struct packed {
    logic               made;
    logic [BACK_W-1:0]  back;
    logic [LINES_W-1:0] lines;
    logic               last_flag;
  } line_result_t;

  // Shadow registers and text state
  logic [MAXLEN_W-1:0] wrap_len;
  logic [TAB_W-1:0]    tab_stop;
  logic [COL_W-1:0]    cur_col;
  logic [SINCE_W-1:0]  word_run;
  logic                ws_on_line;
  logic [LINES_W-1:0]  line_count;

  line_result_t expected_q[$];

  function void bump_lines();
    if (line_count != LINES_MAX) line_count = line_count + 1'b1;
  endfunction

  function void clear_text();
    cur_col    = '0;
    word_run   = '0;
    ws_on_line = 1'b0;
    line_count = '0;
  endfunction

  // Ordinary byte handling once the column has been advanced.
  function void take_byte(logic [BYTE_W-1:0] b, int unsigned col);
    int unsigned ts;
    if (b == LINE_FEED) begin
      bump_lines();
      col        = 0;
      ws_on_line = 1'b0;
      word_run   = '0;
    end else if (b == TAB_CHAR) begin
      ts         = (tab_stop == '0) ? 1 : tab_stop;
      col        = col + (ts - (col % ts));
      ws_on_line = 1'b1;
      word_run   = '0;
    end else if (b == SPACE_CHAR) begin
      ws_on_line = 1'b1;
      word_run   = '0;
    end else if (ws_on_line && word_run < SINCE_MAX) begin
      word_run = word_run + 1'b1;
    end
    cur_col = col[COL_W-1:0];
  endfunction

  function line_result_t wrap_byte(logic [BYTE_W-1:0] b, logic last);
    line_result_t      r;
    int unsigned       col;
    int unsigned       k;
    logic [BYTE_W-1:0] landed;
    r      = '0;
    landed = b;
    col    = cur_col + 1;
    if (col < wrap_len) begin
      take_byte(b, col);
    end else if (ws_on_line) begin
      // earlier whitespace turns into the newline, bytes after it recounted
      k          = word_run + 1;
      r.made     = 1'b1;
      r.back     = (k > SINCE_MAX) ? SINCE_MAX : k[BACK_W-1:0];
      bump_lines();
      ws_on_line = 1'b0;
      word_run   = '0;
      take_byte(b, k);
    end else begin
      // no whitespace on the line: this byte is replaced
      r.made     = 1'b1;
      r.back     = '0;
      bump_lines();
      cur_col    = '0;
      ws_on_line = 1'b0;
      word_run   = '0;
      landed     = LINE_FEED;
    end
    if (last && landed != LINE_FEED) bump_lines();
    r.lines     = line_count;
    r.last_flag = last;
    if (last) clear_text();
    return r;
  endfunction

  task note_mismatch(string what, longint unsigned want, longint unsigned got);
    if (errors < 10)
      $display("[%0t] mismatch on result %0d, %s: expected %0h, got %0h",
               $realtime, results_seen, what, want, got);
    errors++;
  endtask

  initial begin
    errors       = 0;
    pending      = 0;
    results_seen = 0;
    breaks_seen  = 0;
  end

  always @(posedge clk) begin
    line_result_t want;
    if (!rst_n) begin
      wrap_len = MAXLEN_RESET;
      tab_stop = TAB_RESET;
      clear_text();
      expected_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_WRAP_LEN) wrap_len = cfg_pwdata[MAXLEN_W-1:0];
        else                              tab_stop = cfg_pwdata[TAB_W-1:0];
      end
      if (out_mon.valid && out_mon.ready) begin
        if (out_mon.break_made === 1'b1) breaks_seen++;
        if (expected_q.size() == 0) begin
          note_mismatch("unexpected result", 0, out_mon.lines_so_far);
        end else begin
          want = expected_q.pop_front();
          if (out_mon.break_made !== want.made)
            note_mismatch("break_made", want.made, out_mon.break_made);
          if (out_mon.break_back !== want.back)
            note_mismatch("break_back", want.back, out_mon.break_back);
          if (out_mon.lines_so_far !== want.lines)
            note_mismatch("lines_so_far", want.lines, out_mon.lines_so_far);
          if (out_mon.final_flag !== want.last_flag)
            note_mismatch("final_flag", want.last_flag, out_mon.final_flag);
        end
        results_seen++;
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(wrap_byte(in_mon.text_byte, in_mon.is_last));
    end
    pending <= expected_q.size();
  end

endmodule

// ----- dv/tb_word_wrap_line_counter_unit.sv -----
// Testbench top: clock, reset, text stimulus, register writes, watchdog and verdict.
`timescale 1ns / 1ps
module tb_word_wrap_line_counter_unit;
  import wwlc_pkg::*;

  // Byte addresses of the two registers (4 bytes apart)
  localparam logic [APB_AW-1:0] ADDR_WRAP_LEN = {REG_WRAP_LEN, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_TAB_SIZE = {REG_TAB_SIZE, 2'b00};

  localparam logic [BYTE_W-1:0] LOWER_A  = 8'h61;
  localparam int ITEM_TARGET    = 800;
  localparam int LONG_HOLD      = 400;   // receiver hold-off for the backpressure phase
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no request accepted on either side
  localparam int TAIL_CYCLES    = 20;

  logic clk;
  logic rst_n;

  wwlc_in_if  in_ch ();
  wwlc_out_if out_ch ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int fail_count;
  int pending_cnt;
  int results_seen;
  int breaks_seen;

  int  items_sent;
  int  reg_writes;
  int  stall_cycles;
  bit  hold_req;   // raised once by the stimulus, served by the receiver
  bit  in_fast;    // sender stretch without gaps

  word_wrap_line_counter_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  wwlc_line_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_pready   (cfg_pready),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .errors       (fail_count),
    .pending      (pending_cnt),
    .results_seen (results_seen),
    .breaks_seen  (breaks_seen)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Every DUT input known from time zero
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.text_byte = '0;
    in_ch.is_last  = 1'b0;
    out_ch.ready   = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    items_sent     = 0;
    reg_writes     = 0;
    stall_cycles   = 0;
    hold_req       = 1'b0;
    in_fast        = 1'b0;
  end

  // Random gap drawn per request, or none during a fast stretch
  function automatic int draw_gap(bit fast);
    if (fast || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Mostly prose-like text with whitespace; a slice of arbitrary bytes as noise
  function automatic logic [BYTE_W-1:0] pick_char();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return LOWER_A + BYTE_W'($urandom_range(0, 25));
    if (roll < 70) return SPACE_CHAR;
    if (roll < 78) return TAB_CHAR;
    if (roll < 83) return LINE_FEED;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Offer one text byte and hold it until accepted. valid stays high across
  // back-to-back requests, so it is never lowered and raised in one step.
  task automatic push_byte(logic [BYTE_W-1:0] b, logic last);
    int gap;
    if ($urandom_range(0, 39) == 0) in_fast = !in_fast;
    gap = draw_gap(in_fast);
    if (gap > 0) begin
      in_ch.valid     <= 1'b0;
      in_ch.text_byte <= BYTE_W'($urandom);   // junk while idle, must be ignored
      in_ch.is_last   <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.is_last   <= last;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    items_sent++;
  endtask

  // Stop offering and let every outstanding result come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (3) @(posedge clk);
  endtask

  // APB write: setup, then access until pready, then back to idle
  task automatic reg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  function automatic logic [APB_DW-1:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return 1023;
      4:       return $urandom;              // upper bits dropped by the register
      5, 6:    return $urandom_range(2, 1023);
      default: return $urandom_range(3, 24); // short lines, lots of breaks
    endcase
  endfunction

  function automatic logic [APB_DW-1:0] pick_tab();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return 64;
      3:       return 127;
      4:       return $urandom;
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  // New settings between phases; sometimes none, so text carries over
  task automatic retune();
    case ($urandom_range(0, 3))
      0: begin
        reg_write(ADDR_WRAP_LEN, pick_length());
        reg_write(ADDR_TAB_SIZE, pick_tab());
      end
      1: reg_write(ADDR_WRAP_LEN, pick_length());
      2: reg_write(ADDR_TAB_SIZE, pick_tab());
      default: ;
    endcase
  endtask

  // Receiver: random hold-offs, fast stretches, one long hold for backpressure
  initial begin
    int  gap;
    bit  out_fast;
    bit  hold_done;
    out_fast  = 1'b0;
    hold_done = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_fast = !out_fast;
      gap = draw_gap(out_fast);
      if (hold_req && !hold_done) begin
        gap       = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Watchdog: too long without any request moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_word_wrap_line_counter_unit failed");
        $finish;
      end
    end
  end

  // Main stimulus
  initial begin
    int phase_no;
    int n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings (80 / 8): byte extremes, each whitespace kind, end of text
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(TAB_CHAR, 1'b0);
    push_byte(SPACE_CHAR, 1'b0);
    push_byte(LOWER_A, 1'b0);
    push_byte(LINE_FEED, 1'b0);
    push_byte(LOWER_A + 8'd1, 1'b1);   // last byte not a newline: one more line
    push_byte(LINE_FEED, 1'b1);        // text ending in a newline
    drain();

    // Zero line length and zero tab size: every byte replaced by the break
    reg_write(ADDR_WRAP_LEN, 0);
    reg_write(ADDR_TAB_SIZE, 0);
    push_byte(LOWER_A, 1'b0);
    push_byte(TAB_CHAR, 1'b0);
    push_byte(LOWER_A + 8'd2, 1'b1);
    drain();

    // Line length of one behaves the same
    reg_write(ADDR_WRAP_LEN, 1);
    push_byte(LOWER_A + 8'd3, 1'b0);
    push_byte(SPACE_CHAR, 1'b1);
    drain();

    // Length 6 with a space on the line, left mid-text
    reg_write(ADDR_WRAP_LEN, 6);
    push_byte(LOWER_A, 1'b0);
    push_byte(SPACE_CHAR, 1'b0);
    push_byte(LOWER_A + 8'd1, 1'b0);
    push_byte(LOWER_A + 8'd2, 1'b0);
    push_byte(LOWER_A + 8'd3, 1'b0);
    drain();

    // Lowered to 2 mid-text: the recount already exceeds the
    // length, no second break, the following byte breaks instead
    reg_write(ADDR_WRAP_LEN, 2);
    push_byte(LOWER_A + 8'd4, 1'b0);
    push_byte(LOWER_A + 8'd5, 1'b0);
    push_byte(LOWER_A + 8'd6, 1'b1);
    drain();

    // Longest line length with tab size 64: long tab jumps
    reg_write(ADDR_WRAP_LEN, 1023);
    reg_write(ADDR_TAB_SIZE, 64);
    push_byte(TAB_CHAR, 1'b0);
    push_byte(LOWER_A, 1'b0);
    push_byte(LINE_FEED, 1'b1);
    drain();

    // Random phases, each under its own settings
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      retune();
      if (phase_no == 1) hold_req = 1'b1;   // block fills, input stalls
      n = $urandom_range(60, 120);
      repeat (n) push_byte(pick_char(), $urandom_range(0, 39) == 0);
      drain();
      phase_no++;
    end
    push_byte(pick_char(), 1'b1);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d text bytes, %0d results, %0d with an inserted break",
             items_sent, results_seen, breaks_seen);
    $display("across %0d register writes incl. zero, minimum and maximum settings",
             reg_writes);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("tb_word_wrap_line_counter_unit passed");
    end else begin
      $display("tb_word_wrap_line_counter_unit failed");
    end
    $finish;
  end

endmodule
